[sv/tbplc_pkg.sv]
// Types and constants shared by the two-button PIN lock controller.
package tbplc_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned NIB_W  = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [DATA_W-1:0] SAT16 = 16'hFFFF;

  localparam logic [DATA_W-1:0] DEBOUNCE_RST    = 16'd200;
  localparam logic [DATA_W-1:0] LONG_PRESS_RST  = 16'd2000;
  localparam logic [DATA_W-1:0] RESULT_HOLD_RST = 16'd2000;

  localparam logic [NIB_W-1:0] DIGIT_MAX = 4'd9;
  localparam int unsigned SHOWN_DIGITS = 4;

  typedef enum logic [1:0] {
    MODE_LOCKED  = 2'd0,
    MODE_CHANGE  = 2'd1,
    MODE_GRANTED = 2'd2,
    MODE_DENIED  = 2'd3
  } mode_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE    = 2'd0,
    CFG_LONG_PRESS  = 2'd1,
    CFG_RESULT_HOLD = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic              opcode;
    logic              button_a_level;
    logic              button_b_level;
    logic [DATA_W-1:0] load_pin_value;
  } in_req_t;

  typedef struct packed {
    logic [1:0]        lock_mode;
    logic [1:0]        digits_entered;
    logic [NIB_W-1:0]  digit_now;
    logic              old_pin_ok;
    logic              servo_opened;
    logic              pin_saved;
    logic [DATA_W-1:0] saved_pin_value;
    logic [DATA_W-1:0] entry_digits;
  } out_rsp_t;

  function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] v);
    sat_inc = (v == SAT16) ? v : v + 16'd1;
  endfunction

endpackage

[sv/two_button_pin_lock_controller.sv]
// Two-button PIN lock controller: debounce, digit entry, PIN check and change.
//
// One request per cycle while in_stall is low: each accepted request (a 1 ms tick with
// button levels, or a PIN load) updates the lock state and registers one result
// in the output register. Throughput is one request per clock while in_stall is
// low. in_stall rises only while a finished result is held by out_stall. Timers
// count ticks and saturate at 65535; a debounce time of 65535 blocks that button.
// PIN_LENGTH sets the digits compared; only the first four show in the 16-bit
// fields.
module two_button_pin_lock_controller #(
  parameter int unsigned PIN_LENGTH = 4
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  output logic                                        in_stall,
  input  tbplc_pkg::in_req_t                          in_data,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output tbplc_pkg::out_rsp_t                         out_data,
  input  logic                                        cfg_we,
  input  logic [tbplc_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic [tbplc_pkg::DATA_W-1:0]                cfg_wdata
);

  localparam int unsigned CW = (PIN_LENGTH > 1) ? $clog2(PIN_LENGTH) : 1;
  localparam logic [CW-1:0] CNT_LAST = CW'(PIN_LENGTH - 1);

  // config
  logic [tbplc_pkg::DATA_W-1:0] debounce_r, long_press_r, result_hold_r;

  // lock state
  tbplc_pkg::mode_t              mode_r, mode_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [tbplc_pkg::NIB_W-1:0]   sel_r, sel_nxt;
  logic                          ovf_r, ovf_nxt;
  logic                          servo_r, servo_nxt;
  logic [1:0]                    prev_r, prev_nxt;
  logic [tbplc_pkg::DATA_W-1:0]  db_a_r, db_a_nxt;
  logic [tbplc_pkg::DATA_W-1:0]  db_b_r, db_b_nxt;
  logic                          hold_act_r, hold_act_nxt;
  logic [tbplc_pkg::DATA_W-1:0]  hold_cnt_r, hold_cnt_nxt;
  logic [tbplc_pkg::DATA_W-1:0]  rt_r, rt_nxt;
  logic [tbplc_pkg::NIB_W-1:0]   entry_r [PIN_LENGTH];
  logic [tbplc_pkg::NIB_W-1:0]   entry_nxt [PIN_LENGTH];
  logic [tbplc_pkg::NIB_W-1:0]   pin_r [PIN_LENGTH];
  logic [tbplc_pkg::NIB_W-1:0]   pin_nxt [PIN_LENGTH];
  logic [tbplc_pkg::NIB_W-1:0]   load_digit [PIN_LENGTH];
  logic                          saved;
  logic                          match;

  // result register
  logic                 out_valid_r;
  tbplc_pkg::out_rsp_t  out_data_r;
  tbplc_pkg::out_rsp_t  rsp;

  logic in_fire;
  logic [CW+1:0] cnt_ext;
  logic [tbplc_pkg::DATA_W-1:0] pin_packed, entry_packed;

  assign in_stall  = out_valid_r && out_stall;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  for (genvar g = 0; g < PIN_LENGTH; g++) begin : g_load
    if (g < tbplc_pkg::SHOWN_DIGITS) begin : g_nib
      assign load_digit[g] = in_data.load_pin_value[tbplc_pkg::DATA_W-1-4*g -: 4];
    end else begin : g_zero
      assign load_digit[g] = '0;
    end
  end

  for (genvar g = 0; g < tbplc_pkg::SHOWN_DIGITS; g++) begin : g_pack
    if (g < PIN_LENGTH) begin : g_nib
      assign pin_packed[tbplc_pkg::DATA_W-1-4*g -: 4]   = pin_nxt[g];
      assign entry_packed[tbplc_pkg::DATA_W-1-4*g -: 4] = entry_nxt[g];
    end else begin : g_zero
      assign pin_packed[tbplc_pkg::DATA_W-1-4*g -: 4]   = '0;
      assign entry_packed[tbplc_pkg::DATA_W-1-4*g -: 4] = '0;
    end
  end

  // next state
  always_comb begin
    mode_nxt     = mode_r;
    cnt_nxt      = cnt_r;
    sel_nxt      = sel_r;
    ovf_nxt      = ovf_r;
    servo_nxt    = servo_r;
    prev_nxt     = prev_r;
    db_a_nxt     = db_a_r;
    db_b_nxt     = db_b_r;
    hold_act_nxt = hold_act_r;
    hold_cnt_nxt = hold_cnt_r;
    rt_nxt       = rt_r;
    entry_nxt    = entry_r;
    pin_nxt      = pin_r;
    saved        = 1'b0;
    match        = 1'b1;

    if (in_data.opcode == tbplc_pkg::OP_LOAD) begin
      for (int i = 0; i < PIN_LENGTH; i++) pin_nxt[i] = load_digit[i];
    end else begin
      db_a_nxt = tbplc_pkg::sat_inc(db_a_r);
      db_b_nxt = tbplc_pkg::sat_inc(db_b_r);
      rt_nxt   = tbplc_pkg::sat_inc(rt_r);

      // long press of B
      if (!in_data.button_b_level) begin
        if (!hold_act_r) begin
          hold_act_nxt = 1'b1;
          hold_cnt_nxt = '0;
        end else begin
          hold_cnt_nxt = tbplc_pkg::sat_inc(hold_cnt_r);
        end
        if (hold_cnt_nxt >= long_press_r && mode_r == tbplc_pkg::MODE_LOCKED) begin
          mode_nxt = tbplc_pkg::MODE_CHANGE;
          for (int i = 0; i < PIN_LENGTH; i++) entry_nxt[i] = '0;
          cnt_nxt      = '0;
          sel_nxt      = '0;
          ovf_nxt      = 1'b0;
          hold_act_nxt = 1'b0;
        end
      end else begin
        hold_act_nxt = 1'b0;
      end

      // button A steps the digit
      if (prev_r[0] && !in_data.button_a_level && db_a_nxt > debounce_r) begin
        db_a_nxt = '0;
        sel_nxt  = (sel_nxt >= tbplc_pkg::DIGIT_MAX) ? '0 : sel_nxt + 4'd1;
      end

      // button B commits the digit
      if (prev_r[1] && !in_data.button_b_level && db_b_nxt > debounce_r) begin
        db_b_nxt = '0;
        entry_nxt[cnt_nxt] = sel_nxt;
        sel_nxt = '0;
        for (int i = 0; i < PIN_LENGTH; i++) begin
          if (entry_nxt[i] != pin_r[i]) match = 1'b0;
        end
        if (cnt_nxt == CNT_LAST) begin
          if (mode_nxt == tbplc_pkg::MODE_CHANGE) begin
            if (!ovf_nxt) begin
              if (match) begin
                ovf_nxt = 1'b1;
              end else begin
                mode_nxt = tbplc_pkg::MODE_LOCKED;
                ovf_nxt  = 1'b0;
              end
            end else begin
              pin_nxt  = entry_nxt;
              saved    = 1'b1;
              mode_nxt = tbplc_pkg::MODE_LOCKED;
              ovf_nxt  = 1'b0;
            end
            for (int i = 0; i < PIN_LENGTH; i++) entry_nxt[i] = '0;
            sel_nxt = '0;
          end else begin
            if (match) begin
              mode_nxt  = tbplc_pkg::MODE_GRANTED;
              servo_nxt = 1'b1;
            end else begin
              mode_nxt = tbplc_pkg::MODE_DENIED;
            end
            rt_nxt = '0;
          end
          cnt_nxt = '0;
        end else begin
          cnt_nxt = cnt_nxt + CW'(1);
        end
      end

      // relock after the hold time
      if ((mode_nxt == tbplc_pkg::MODE_GRANTED || mode_nxt == tbplc_pkg::MODE_DENIED) &&
          rt_nxt >= result_hold_r) begin
        mode_nxt  = tbplc_pkg::MODE_LOCKED;
        servo_nxt = 1'b0;
        for (int i = 0; i < PIN_LENGTH; i++) entry_nxt[i] = '0;
        cnt_nxt = '0;
        sel_nxt = '0;
      end

      prev_nxt = {in_data.button_b_level, in_data.button_a_level};
    end
  end

  // result
  assign cnt_ext = {2'b00, cnt_nxt};

  always_comb begin
    rsp.lock_mode       = mode_nxt;
    rsp.digits_entered  = cnt_ext[1:0];
    rsp.digit_now       = sel_nxt;
    rsp.old_pin_ok      = ovf_nxt;
    rsp.servo_opened    = servo_nxt;
    rsp.pin_saved       = saved;
    rsp.saved_pin_value = pin_packed;
    rsp.entry_digits    = entry_packed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r    <= tbplc_pkg::DEBOUNCE_RST;
      long_press_r  <= tbplc_pkg::LONG_PRESS_RST;
      result_hold_r <= tbplc_pkg::RESULT_HOLD_RST;
    end else if (cfg_we) begin
      unique case (tbplc_pkg::cfg_idx_t'(cfg_index))
        tbplc_pkg::CFG_DEBOUNCE:    debounce_r    <= cfg_wdata;
        tbplc_pkg::CFG_LONG_PRESS:  long_press_r  <= cfg_wdata;
        tbplc_pkg::CFG_RESULT_HOLD: result_hold_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= tbplc_pkg::MODE_LOCKED;
      cnt_r      <= '0;
      sel_r      <= '0;
      ovf_r      <= 1'b0;
      servo_r    <= 1'b0;
      prev_r     <= 2'b11;
      db_a_r     <= '0;
      db_b_r     <= '0;
      hold_act_r <= 1'b0;
      hold_cnt_r <= '0;
      rt_r       <= '0;
      for (int i = 0; i < PIN_LENGTH; i++) begin
        entry_r[i] <= '0;
        pin_r[i]   <= (i < tbplc_pkg::SHOWN_DIGITS) ? 4'(i + 1) : '0;
      end
    end else if (in_fire) begin
      mode_r     <= mode_nxt;
      cnt_r      <= cnt_nxt;
      sel_r      <= sel_nxt;
      ovf_r      <= ovf_nxt;
      servo_r    <= servo_nxt;
      prev_r     <= prev_nxt;
      db_a_r     <= db_a_nxt;
      db_b_r     <= db_b_nxt;
      hold_act_r <= hold_act_nxt;
      hold_cnt_r <= hold_cnt_nxt;
      rt_r       <= rt_nxt;
      entry_r    <= entry_nxt;
      pin_r      <= pin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= rsp;
    end
  end

`ifndef NO_ASSERTIONS
  a_servo_only_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    servo_r |-> (mode_r == tbplc_pkg::MODE_GRANTED || mode_r == tbplc_pkg::MODE_DENIED))
    else $error("servo open outside granted/denied");

  a_verified_only_in_change: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> mode_r == tbplc_pkg::MODE_CHANGE)
    else $error("old PIN flag set outside change mode");

  a_digit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r <= tbplc_pkg::DIGIT_MAX)
    else $error("selected digit out of range");

  a_saved_relocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.pin_saved) |->
      out_data_r.lock_mode == tbplc_pkg::MODE_LOCKED)
    else $error("PIN saved without relock");

  a_load_keeps_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.opcode == tbplc_pkg::OP_LOAD) |=> mode_r == $past(mode_r))
    else $error("PIN load changed lock mode");
`endif

endmodule

[bench/tb_two_button_pin_lock_controller.sv]
// Testbench for the two-button PIN lock controller: queued requests, predicted results.
module tb_two_button_pin_lock_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import tbplc_pkg::*;

  localparam int PIN_LEN = 4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_rsp_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_wdata = '0;

  two_button_pin_lock_controller #(.PIN_LENGTH(PIN_LEN)) u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // lock predictor state
  logic [DATA_W-1:0] deb_lim, lp_lim, hold_lim;
  mode_t lk_mode;
  logic [PIN_LEN-1:0][NIB_W-1:0] entry_nib, pin_nib;
  int unsigned entry_cnt;
  logic [NIB_W-1:0] sel_digit;
  logic old_ok, latch_open, hold_on;
  logic [1:0] prev_lvl;
  logic [DATA_W-1:0] since_a, since_b, hold_cnt, shown_timer;

  in_req_t req_q[$];
  out_rsp_t lock_expect_q[$];
  int fed;
  bit calm;
  int slip_cnt;
  int idle_left;
  int stall_left;
  logic took_q = 1'b0;

  function automatic logic [DATA_W-1:0] bump(input logic [DATA_W-1:0] v);
    return v + {{(DATA_W-1){1'b0}}, ~&v};
  endfunction

  function automatic logic [DATA_W-1:0] shown(input logic [PIN_LEN-1:0][NIB_W-1:0] d);
    logic [DATA_W-1:0] w;
    w = '0;
    for (int i = 0; i < PIN_LEN && i < SHOWN_DIGITS; i++) w[DATA_W-1-NIB_W*i -: NIB_W] = d[i];
    return w;
  endfunction

  task automatic wipe_entry();
    entry_nib = '0;
    entry_cnt = 0;
    sel_digit = '0;
  endtask

  task automatic reset_lock_model();
    deb_lim = DEBOUNCE_RST;
    lp_lim = LONG_PRESS_RST;
    hold_lim = RESULT_HOLD_RST;
    lk_mode = MODE_LOCKED;
    wipe_entry();
    pin_nib = '0;
    for (int i = 0; i < PIN_LEN && i < SHOWN_DIGITS; i++) pin_nib[i] = NIB_W'(i + 1);
    old_ok = 1'b0;
    latch_open = 1'b0;
    prev_lvl = 2'b11;
    since_a = '0;
    since_b = '0;
    hold_on = 1'b0;
    hold_cnt = '0;
    shown_timer = '0;
  endtask

  task automatic step_lock(input in_req_t r, output out_rsp_t o);
    logic saved;
    saved = 1'b0;
    if (r.opcode == OP_LOAD) begin
      pin_nib = '0;
      for (int i = 0; i < PIN_LEN && i < SHOWN_DIGITS; i++)
        pin_nib[i] = r.load_pin_value[DATA_W-1-NIB_W*i -: NIB_W];
    end else begin
      since_a = bump(since_a);
      since_b = bump(since_b);
      shown_timer = bump(shown_timer);

      if (!r.button_b_level) begin
        if (!hold_on) begin
          hold_on = 1'b1;
          hold_cnt = '0;
        end else begin
          hold_cnt = bump(hold_cnt);
        end
        if (hold_cnt >= lp_lim && lk_mode == MODE_LOCKED) begin
          lk_mode = MODE_CHANGE;
          wipe_entry();
          old_ok = 1'b0;
          hold_on = 1'b0;
        end
      end else begin
        hold_on = 1'b0;
      end

      if (prev_lvl[0] && !r.button_a_level && since_a > deb_lim) begin
        since_a = '0;
        sel_digit = (sel_digit >= DIGIT_MAX) ? '0 : sel_digit + 1'b1;
      end

      if (prev_lvl[1] && !r.button_b_level && since_b > deb_lim) begin
        since_b = '0;
        if (entry_cnt < PIN_LEN) entry_nib[entry_cnt] = sel_digit;
        entry_cnt++;
        sel_digit = '0;
        if (entry_cnt >= PIN_LEN) begin
          if (lk_mode == MODE_CHANGE) begin
            if (!old_ok) begin
              if (entry_nib == pin_nib) old_ok = 1'b1;
              else lk_mode = MODE_LOCKED;
            end else begin
              pin_nib = entry_nib;
              saved = 1'b1;
              lk_mode = MODE_LOCKED;
              old_ok = 1'b0;
            end
            wipe_entry();
          end else begin
            if (entry_nib == pin_nib) begin
              lk_mode = MODE_GRANTED;
              latch_open = 1'b1;
            end else begin
              lk_mode = MODE_DENIED;
            end
            shown_timer = '0;
          end
          entry_cnt = 0;
        end
      end

      if ((lk_mode == MODE_GRANTED || lk_mode == MODE_DENIED) && shown_timer >= hold_lim) begin
        lk_mode = MODE_LOCKED;
        latch_open = 1'b0;
        wipe_entry();
      end

      prev_lvl = {r.button_b_level, r.button_a_level};
    end

    o.lock_mode = lk_mode;
    o.digits_entered = entry_cnt[1:0];
    o.digit_now = sel_digit;
    o.old_pin_ok = old_ok;
    o.servo_opened = latch_open;
    o.pin_saved = saved;
    o.saved_pin_value = shown(pin_nib);
    o.entry_digits = shown(entry_nib);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_slip(input string what);
    if (slip_cnt < 40) $display("[%0t] mismatch: %s", $time, what);
    slip_cnt++;
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] got, want);
    if (got !== want) flag_slip($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) took_q <= rst_n && in_valid && !in_stall;

  // request driver
  always @(negedge clk) begin
    out_rsp_t rsp;
    if (took_q) begin
      step_lock(in_data, rsp);
      lock_expect_q.push_back(rsp);
    end
    if (!in_valid || took_q) begin
      if (idle_left > 0) begin
        idle_left--;
        in_valid <= 1'b0;
      end else if (req_q.size() != 0) begin
        in_data <= req_q.pop_front();
        in_valid <= 1'b1;
        idle_left = calm ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_left = pick_gap();
    end else begin
      out_stall <= 1'b0;
      stall_left = $urandom_range(0, 6);
    end
  end

  // result monitor
  always @(posedge clk) begin
    out_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (lock_expect_q.size() == 0) begin
        flag_slip("result with no request pending");
      end else begin
        want = lock_expect_q.pop_front();
        check_field("lock_mode", DATA_W'(out_data.lock_mode), DATA_W'(want.lock_mode));
        check_field("digits_entered", DATA_W'(out_data.digits_entered),
                    DATA_W'(want.digits_entered));
        check_field("digit_now", DATA_W'(out_data.digit_now), DATA_W'(want.digit_now));
        check_field("old_pin_ok", DATA_W'(out_data.old_pin_ok), DATA_W'(want.old_pin_ok));
        check_field("servo_opened", DATA_W'(out_data.servo_opened),
                    DATA_W'(want.servo_opened));
        check_field("pin_saved", DATA_W'(out_data.pin_saved), DATA_W'(want.pin_saved));
        check_field("saved_pin_value", out_data.saved_pin_value, want.saved_pin_value);
        check_field("entry_digits", out_data.entry_digits, want.entry_digits);
      end
    end
  end

  task automatic push_tick(input logic a, input logic b);
    in_req_t t;
    t.opcode = OP_TICK;
    t.button_a_level = a;
    t.button_b_level = b;
    t.load_pin_value = DATA_W'($urandom);
    req_q.push_back(t);
    fed++;
  endtask

  task automatic push_load(input logic [DATA_W-1:0] v);
    in_req_t t;
    t.opcode = OP_LOAD;
    t.button_a_level = 1'($urandom_range(0, 1));
    t.button_b_level = 1'($urandom_range(0, 1));
    t.load_pin_value = v;
    req_q.push_back(t);
    fed++;
  endtask

  task automatic rest(input int n);
    repeat (n) push_tick(1'b1, 1'b1);
  endtask

  function automatic int press_gap();
    if (deb_lim > 16'd50) return $urandom_range(1, 3);
    if ($urandom_range(0, 9) == 0) return $urandom_range(1, int'(deb_lim) + 1);
    return int'(deb_lim) + $urandom_range(1, 2);
  endfunction

  task automatic tap(input logic is_b);
    push_tick(is_b, !is_b);
    rest(press_gap());
  endtask

  task automatic key_in(input logic [NIB_W-1:0] d);
    int n;
    n = d + (($urandom_range(0, 19) == 0) ? 10 : 0);
    repeat (n) tap(1'b0);
    tap(1'b1);
  endtask

  task automatic key_code(input logic [DATA_W-1:0] code);
    for (int i = 0; i < SHOWN_DIGITS; i++) key_in(code[DATA_W-1-NIB_W*i -: NIB_W]);
  endtask

  function automatic logic [DATA_W-1:0] pick_code();
    logic [DATA_W-1:0] w;
    for (int i = 0; i < SHOWN_DIGITS; i++)
      w[NIB_W*i +: NIB_W] = ($urandom_range(0, 4) != 0) ? NIB_W'($urandom_range(0, 3)) :
                                                           NIB_W'($urandom_range(0, 9));
    return w;
  endfunction

  task automatic hold_rest();
    rest((hold_lim < 16'd40) ? int'(hold_lim) + $urandom_range(0, 2) : $urandom_range(1, 20));
  endtask

  task automatic long_hold();
    int n;
    n = (lp_lim < 16'd40) ? int'(lp_lim) + 1 + $urandom_range(0, 2) : $urandom_range(1, 30);
    repeat (n) push_tick(1'b1, 1'b0);
    rest(press_gap());
  endtask

  task automatic noise(input int n);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) push_load(DATA_W'($urandom));
      else push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic one_sequence();
    logic [DATA_W-1:0] pin_w;
    pin_w = shown(pin_nib);
    calm = ($urandom_range(0, 6) == 0);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        key_code(($urandom_range(0, 3) != 0) ? pin_w : pick_code());
        hold_rest();
      end
      3, 4: begin
        long_hold();
        key_code(($urandom_range(0, 4) != 0) ? pin_w : pick_code());
        key_code(pick_code());
        hold_rest();
      end
      5: push_load(($urandom_range(0, 5) != 0) ? pick_code() : DATA_W'($urandom));
      6: noise($urandom_range(4, 30));
      7: begin
        repeat ($urandom_range(1, 3)) key_in(NIB_W'($urandom_range(0, 9)));
        hold_rest();
      end
      8: begin
        // wrong code while open: denied must keep the servo open
        key_code(pin_w);
        key_code(pick_code());
        hold_rest();
      end
      default: rest($urandom_range(1, 12));
    endcase
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (req_q.size() != 0 || in_valid);
  endtask

  task automatic settle();
    wait_drained();
    for (int spin = 0; spin < 5000 && lock_expect_q.size() != 0; spin++) @(posedge clk);
    if (lock_expect_q.size() != 0) begin
      flag_slip($sformatf("%0d results never arrived", lock_expect_q.size()));
      lock_expect_q.delete();
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic set_regs(input logic [DATA_W-1:0] deb, lp, hold);
    settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DEBOUNCE;
    cfg_wdata <= deb;
    deb_lim = deb;
    @(negedge clk);
    cfg_index <= CFG_LONG_PRESS;
    cfg_wdata <= lp;
    lp_lim = lp;
    @(negedge clk);
    cfg_index <= CFG_RESULT_HOLD;
    cfg_wdata <= hold;
    hold_lim = hold;
    @(negedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= DATA_W'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [DATA_W-1:0] deb, lp, hold, input int budget);
    int start;
    set_regs(deb, lp, hold);
    start = fed;
    while (fed - start < budget) begin
      one_sequence();
      wait_drained();
    end
  endtask

  initial begin
    reset_lock_model();
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    @(posedge clk);

    // default timing: presses too soon after reset are ignored; odd PIN loads
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b0);
    push_load(16'hFFFF);
    push_load(16'h0000);
    push_tick(1'b1, 1'b1);
    push_load(16'h9876);
    wait_drained();

    // zero hold time: granted relocks on the same tick
    set_regs(16'd0, 16'd30, 16'd0);
    push_load(16'h0120);
    key_code(16'h0120);
    wait_drained();

    run_phase(16'd1, 16'd6, 16'd3, 220);
    run_phase(16'd0, 16'd0, 16'd0, 120);
    run_phase(16'd2, 16'd12, 16'd9, 180);
    run_phase(16'd0, 16'd4, 16'hFFFF, 150);
    run_phase(16'hFFFF, 16'd3, 16'd2, 60);
    run_phase(16'd3, 16'hFFFF, 16'd5, 120);
    run_phase(16'd1, 16'd25, 16'd30, 200);
    run_phase(DEBOUNCE_RST, LONG_PRESS_RST, RESULT_HOLD_RST, 60);

    settle();
    if (slip_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(64'd20_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule
